// ===== design/trqs_pkg.sv =====
// Shared types and constants for the thread ready-queue scheduler.
// Used by trqs_seq and thread_ready_queue_scheduler_core; no dependencies.
package trqs_pkg;

    localparam int DEF_THREAD_COUNT = 16;
    localparam int ID_W             = 4;
    localparam int BITS_W           = 8;
    localparam int IN_DATA_W        = 16;
    localparam int OUT_DATA_W       = 24;

    typedef enum logic [1:0] {
        OP_RESUME  = 2'd0,
        OP_SUSPEND = 2'd1,
        OP_YIELD   = 2'd2,
        OP_SWITCH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_KEEP = 2'd1,
        ACT_LOAD = 2'd2,
        ACT_IDLE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_RD,
        ST_TAIL,
        ST_UL_P,
        ST_UL_N,
        ST_POP,
        ST_CUR_RD,
        ST_CUR,
        ST_DONE
    } seq_state_t;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic [BITS_W-1:0] mode_bits;
        logic [ID_W-1:0]   thread_id;
        op_t               opcode;
    } item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic            switch_pending;
        logic [ID_W-1:0] active_thread;
        logic            current_valid;
        logic [ID_W-1:0] load_thread;
        logic [ID_W-1:0] save_thread;
        logic            save_valid;
        action_t         action;
    } result_t;

endpackage

// ===== design/trqs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module trqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/trqs_seq.sv =====
// Scheduler sequencer: read-modify-write of the thread table memory,
// queue head/tail, current thread and pending-switch flag. Depends on trqs_pkg.
module trqs_seq #(
    parameter int THREAD_COUNT = trqs_pkg::DEF_THREAD_COUNT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  trqs_pkg::item_t                     in_item,
    input  logic                                out_free,
    output logic                                done,
    output trqs_pkg::result_t                   res,
    output logic                                ram_we,
    output logic [$clog2(THREAD_COUNT)-1:0]     ram_waddr,
    output logic [2*$clog2(THREAD_COUNT)+trqs_pkg::BITS_W:0] ram_wdata,
    output logic [$clog2(THREAD_COUNT)-1:0]     ram_raddr,
    input  logic [2*$clog2(THREAD_COUNT)+trqs_pkg::BITS_W:0] ram_rdata
);
    import trqs_pkg::*;

    localparam int TW = $clog2(THREAD_COUNT);
    localparam int unsigned TC = THREAD_COUNT;

    typedef logic [TW-1:0] idx_t;

    typedef struct packed {
        logic [BITS_W-1:0] reasons;
        logic              inq;
        idx_t              nxt;
        idx_t              prv;
    } rec_t;

    localparam rec_t RESET_REC = '{reasons: '1, inq: 1'b0, nxt: '0, prv: '0};

    seq_state_t        state_reg, state_next;
    op_t               op_reg, op_next;
    idx_t              tid_reg, tid_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    idx_t              head_reg, head_next;
    idx_t              tail_reg, tail_next;
    logic              ne_reg, ne_next;
    idx_t              run_reg, run_next;
    logic              rv_reg, rv_next;
    logic              pend_reg, pend_next;
    logic              hn_reg, hn_next;
    idx_t              nx_reg, nx_next;
    action_t           act_reg, act_next;
    logic              sv_reg, sv_next;
    idx_t              st_reg, st_next;
    idx_t              enq_reg, enq_next;
    idx_t              p_reg, p_next;
    idx_t              n_reg, n_next;
    logic [THREAD_COUNT-1:0] vld_reg;
    logic              rdv_reg;

    rec_t rec;
    rec_t wrec;
    idx_t in_tid;
    logic tid_ok;

    assign in_tid = idx_t'(in_item.thread_id);
    assign tid_ok = (32'(in_item.thread_id) < TC);

    // Entries never written read as blocked and unqueued
    assign rec = rdv_reg ? rec_t'(ram_rdata) : RESET_REC;
    assign ram_wdata = wrec;

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            ne_reg    <= 1'b0;
            run_reg   <= '0;
            rv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            vld_reg   <= '0;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ne_reg    <= ne_next;
            run_reg   <= run_next;
            rv_reg    <= rv_next;
            pend_reg  <= pend_next;
            rdv_reg   <= vld_reg[ram_raddr];
            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        tid_reg <= tid_next;
        bits_reg <= bits_next;
        hn_reg  <= hn_next;
        nx_reg  <= nx_next;
        act_reg <= act_next;
        sv_reg  <= sv_next;
        st_reg  <= st_next;
        enq_reg <= enq_next;
        p_reg   <= p_next;
        n_reg   <= n_next;
    end

    // Sequencer: next state, table accesses, queue updates
    always_comb begin
        logic [BITS_W-1:0] nb;

        nb         = '0;
        state_next = state_reg;
        op_next    = op_reg;
        tid_next   = tid_reg;
        bits_next  = bits_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        ne_next    = ne_reg;
        run_next   = run_reg;
        rv_next    = rv_reg;
        pend_next  = pend_reg;
        hn_next    = hn_reg;
        nx_next    = nx_reg;
        act_next   = act_reg;
        sv_next    = sv_reg;
        st_next    = st_reg;
        enq_next   = enq_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        wrec       = rec;
        ram_we     = 1'b0;
        ram_waddr  = tid_reg;
        ram_raddr  = tid_reg;
        in_ready   = 1'b0;
        done       = 1'b0;
        res        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next   = in_item.opcode;
                    tid_next  = in_tid;
                    bits_next = in_item.mode_bits;
                    hn_next   = 1'b0;
                    sv_next   = 1'b0;
                    st_next   = '0;
                    act_next  = ACT_NONE;
                    state_next = ST_DONE;
                    unique case (in_item.opcode)
                        OP_RESUME, OP_SUSPEND: begin
                            if (tid_ok) begin
                                ram_raddr = in_tid;
                                if (in_item.opcode == OP_SUSPEND && rv_reg
                                        && run_reg == in_tid) begin
                                    pend_next = 1'b1;
                                end
                                state_next = ST_T_RD;
                            end
                        end
                        OP_YIELD: begin
                            pend_next = 1'b1;
                        end
                        OP_SWITCH: begin
                            if (pend_reg) begin
                                pend_next = 1'b0;
                                act_next  = ACT_IDLE;
                                if (ne_reg) begin
                                    ram_raddr  = head_reg;
                                    state_next = ST_POP;
                                end else begin
                                    state_next = ST_CUR_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_T_RD: begin
                ram_we     = 1'b1;
                ram_waddr  = tid_reg;
                state_next = ST_DONE;
                if (op_reg == OP_RESUME) begin
                    nb = rec.reasons & ~bits_reg;
                    wrec.reasons = nb;
                    if (nb == '0) begin
                        if (!rv_reg) begin
                            pend_next = 1'b1;
                        end
                        // Append to the tail unless already queued
                        if (!rec.inq) begin
                            wrec.inq = 1'b1;
                            if (ne_reg) begin
                                wrec.prv   = tail_reg;
                                ram_raddr  = tail_reg;
                                enq_next   = tid_reg;
                                state_next = ST_TAIL;
                            end else begin
                                head_next = tid_reg;
                                tail_next = tid_reg;
                                ne_next   = 1'b1;
                            end
                        end
                    end
                end else begin
                    nb = rec.reasons | bits_reg;
                    wrec.reasons = nb;
                    // Unlink a queued thread that became blocked
                    if (nb != '0 && rec.inq) begin
                        wrec.inq = 1'b0;
                        priority if (tid_reg == head_reg && tid_reg == tail_reg) begin
                            ne_next = 1'b0;
                        end else if (tid_reg == head_reg) begin
                            head_next = rec.nxt;
                        end else if (tid_reg == tail_reg) begin
                            tail_next = rec.prv;
                        end else begin
                            p_next     = rec.prv;
                            n_next     = rec.nxt;
                            ram_raddr  = rec.prv;
                            state_next = ST_UL_P;
                        end
                    end
                end
            end

            ST_TAIL: begin
                // Link the old tail forward to the new entry
                wrec.nxt   = enq_reg;
                ram_we     = 1'b1;
                ram_waddr  = tail_reg;
                tail_next  = enq_reg;
                state_next = ST_DONE;
            end

            ST_UL_P: begin
                wrec.nxt   = n_reg;
                ram_we     = 1'b1;
                ram_waddr  = p_reg;
                ram_raddr  = n_reg;
                state_next = ST_UL_N;
            end

            ST_UL_N: begin
                wrec.prv   = p_reg;
                ram_we     = 1'b1;
                ram_waddr  = n_reg;
                state_next = ST_DONE;
            end

            ST_POP: begin
                // Take the head off the queue
                nx_next   = head_reg;
                hn_next   = 1'b1;
                wrec.inq  = 1'b0;
                ram_we    = 1'b1;
                ram_waddr = head_reg;
                if (head_reg == tail_reg) begin
                    ne_next = 1'b0;
                end else begin
                    head_next = rec.nxt;
                end
                state_next = ST_CUR_RD;
            end

            ST_CUR_RD: begin
                if (rv_reg) begin
                    ram_raddr  = run_reg;
                    state_next = ST_CUR;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_CUR: begin
                state_next = ST_DONE;
                ram_waddr  = run_reg;
                if (rec.reasons == '0) begin
                    act_next = ACT_KEEP;
                    if (hn_reg) begin
                        // Save and re-queue the preempted thread
                        sv_next = 1'b1;
                        st_next = run_reg;
                        if (!rec.inq) begin
                            wrec.inq = 1'b1;
                            ram_we   = 1'b1;
                            if (ne_reg) begin
                                wrec.prv   = tail_reg;
                                ram_raddr  = tail_reg;
                                enq_next   = run_reg;
                                state_next = ST_TAIL;
                            end else begin
                                head_next = run_reg;
                                tail_next = run_reg;
                                ne_next   = 1'b1;
                            end
                        end
                    end
                end else begin
                    // Drop the blocked thread
                    sv_next = 1'b1;
                    st_next = run_reg;
                    rv_next = 1'b0;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    if (hn_reg) begin
                        run_next = nx_reg;
                        rv_next  = 1'b1;
                    end
                    done               = 1'b1;
                    res.action         = hn_reg ? ACT_LOAD : act_reg;
                    res.save_valid     = sv_reg;
                    res.save_thread    = ID_W'(st_reg);
                    res.load_thread    = hn_reg ? ID_W'(nx_reg) : '0;
                    res.current_valid  = hn_reg | rv_reg;
                    res.active_thread  = hn_reg ? ID_W'(nx_reg) : ID_W'(run_reg);
                    res.switch_pending = pend_reg;
                    state_next         = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== design/thread_ready_queue_scheduler_core.sv =====
// Thread ready-queue scheduler: one result per item, registered on m_tdata.
// Yield, ignored items and switch requests with nothing pending go straight to the result;
// a switch that re-queues the current thread first pops the queue head, then reads and re-queues the current thread.
// One item at a time: the next input is taken only once the last result has entered the output
// register, after the thread table read-modify-write steps and any wait on m_tready.
// Reset (aresetn low, synchronous) empties the queue, clears the current thread and
// marks every table entry blocked through per-entry valid bits; no clearing pass.
module thread_ready_queue_scheduler_core #(
    parameter int THREAD_COUNT = trqs_pkg::DEF_THREAD_COUNT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // opcode[1:0], thread_id[5:2], mode_bits[13:6], zero[15:14]
    input  logic [trqs_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // action[1:0], save_valid[2], save_thread[6:3], load_thread[10:7],
    // current_valid[11], active_thread[15:12], switch_pending[16], zero[23:17]
    output logic [trqs_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import trqs_pkg::*;

    localparam int TW    = $clog2(THREAD_COUNT);
    localparam int REC_W = 2 * TW + BITS_W + 1;

    item_t            item;
    result_t          res;
    result_t          res_reg;
    logic             m_tvalid_reg;
    logic             done;
    logic             out_free;
    logic             ram_we;
    logic [TW-1:0]    ram_waddr;
    logic [TW-1:0]    ram_raddr;
    logic [REC_W-1:0] ram_wdata;
    logic [REC_W-1:0] ram_rdata;

    assign item     = item_t'(s_tdata[$bits(item_t)-1:0]);
    assign out_free = !m_tvalid_reg || m_tready;

    trqs_seq #(
        .THREAD_COUNT(THREAD_COUNT)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_free  (out_free),
        .done      (done),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    trqs_ram #(
        .WIDTH(REC_W),
        .DEPTH(THREAD_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: load a finished result, drop it on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(res_reg);

endmodule
